### hdl/tter_pkg.sv
// Shared types and codes for the timer table block.
`default_nettype none
package tter_pkg;

   // most expired beats a single tick may return
   localparam int MAX_OUT = 16;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_ADD     = 2'd1,
      MODE_DEL     = 2'd2,
      MODE_DEL_ALL = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      EV_EXPIRED = 2'd0,
      EV_DONE    = 2'd1,
      EV_FULL    = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  timer_id;
      logic [15:0] start_delay;
      logic [15:0] expire_delay;
      logic [15:0] reload_period;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [7:0]  fired_id;
      logic [31:0] fired_deadline;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_SCAN,
      ST_EMIT,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic take_req;
      logic scan_start;
      logic scan_step;
      logic fire;
      logic cmd_exec;
      logic load_rsp;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic found;
      logic last_fire;
      logic is_tick;
   } ctl_sts_type;

endpackage
`default_nettype wire

### hdl/tter_datapath.sv
// Timer table storage, sequential scan and result register.
`default_nettype none
module tter_datapath #(
   parameter int NUM_TIMERS = 16,
   parameter int TIME_BITS  = 32
) (
   input  wire                    clock,
   input  wire                    reset,
   input  tter_pkg::req_type      req_payload,
   input  tter_pkg::ctl_cmd_type  cmd,
   output tter_pkg::ctl_sts_type  sts,
   output tter_pkg::rsp_type      rsp_payload
);
   localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam int FW = $clog2(tter_pkg::MAX_OUT + 1);

   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [NUM_TIMERS-1:0] valid_ff, valid_in, done_ff, done_in;
   logic [7:0]            id_mem [NUM_TIMERS];
   logic [TIME_BITS-1:0]  dl_mem [NUM_TIMERS];
   logic [15:0]           rl_mem [NUM_TIMERS];
   tter_pkg::req_type     req_ff;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  stage_ff;
   logic [IW-1:0]         slot_ff;
   logic [7:0]            rd_id_ff;
   logic [TIME_BITS-1:0]  rd_dl_ff;
   logic [15:0]           rd_rl_ff;
   logic                  best_ok_ff, best_ok_in;
   logic [IW-1:0]         best_ff, best_in;
   logic [TIME_BITS-1:0]  blag_ff, blag_in;
   logic [7:0]            best_id_ff, best_id_in;
   logic [TIME_BITS-1:0]  best_dl_ff, best_dl_in;
   logic [15:0]           best_rl_ff, best_rl_in;
   logic                  more_ok_ff, more_ok_in;
   logic [FW-1:0]         fire_cnt_ff, fire_cnt_in;
   logic                  match_ok_ff, match_ok_in, free_ok_ff, free_ok_in;
   logic [IW-1:0]         match_ff, match_in, free_ff, free_in;
   tter_pkg::rsp_type     rsp_ff;
   logic [IW-1:0]         cur;
   logic [TIME_BITS-1:0]  lag, new_dl;
   logic                  due;
   logic                  last_fire;

   // table is read one entry a cycle; the compare runs in the cycle after the read
   assign cur = idx_ff[IW-1:0];
   assign lag = now_ff - rd_dl_ff;
   assign due = valid_ff[slot_ff] && !done_ff[slot_ff] && !lag[TIME_BITS-1];
   assign new_dl = now_ff + TIME_BITS'(req_ff.start_delay) + TIME_BITS'(req_ff.expire_delay);
   assign last_fire = !more_ok_ff || (fire_cnt_ff == FW'(tter_pkg::MAX_OUT - 1));

   always_comb begin
      now_in      = now_ff;
      valid_in    = valid_ff;
      done_in     = done_ff;
      idx_in      = idx_ff;
      best_ok_in  = best_ok_ff;
      best_in     = best_ff;
      blag_in     = blag_ff;
      best_id_in  = best_id_ff;
      best_dl_in  = best_dl_ff;
      best_rl_in  = best_rl_ff;
      more_ok_in  = more_ok_ff;
      fire_cnt_in = fire_cnt_ff;
      match_ok_in = match_ok_ff;
      match_in    = match_ff;
      free_ok_in  = free_ok_ff;
      free_in     = free_ff;
      if (cmd.take_req) begin
         done_in = '0;
         fire_cnt_in = '0;
         if (req_payload.mode == tter_pkg::MODE_TICK) now_in = now_ff + TIME_BITS'(1);
      end
      if (cmd.scan_start) begin
         idx_in = '0; best_ok_in = 1'b0; more_ok_in = 1'b0;
         match_ok_in = 1'b0; free_ok_in = 1'b0;
      end
      if (cmd.scan_step) idx_in = idx_ff + CW'(1);
      if (stage_ff) begin
         if (due) begin
            // a second due entry means the coming beat is not the last
            if (best_ok_ff) more_ok_in = 1'b1;
            if (!best_ok_ff || lag > blag_ff) begin
               best_ok_in = 1'b1; best_in = slot_ff; blag_in = lag;
               best_id_in = rd_id_ff; best_dl_in = rd_dl_ff; best_rl_in = rd_rl_ff;
            end
         end
         if (!match_ok_ff && valid_ff[slot_ff] && rd_id_ff == req_ff.timer_id) begin
            match_ok_in = 1'b1; match_in = slot_ff;
         end
         if (!free_ok_ff && !valid_ff[slot_ff]) begin
            free_ok_in = 1'b1; free_in = slot_ff;
         end
      end
      if (cmd.fire) begin
         done_in[best_ff] = 1'b1;
         fire_cnt_in = fire_cnt_ff + FW'(1);
         if (best_rl_ff == '0) valid_in[best_ff] = 1'b0;
      end
      if (cmd.cmd_exec) begin
         unique case (tter_pkg::mode_type'(req_ff.mode))
            tter_pkg::MODE_ADD: begin
               if (match_ok_ff)     valid_in[match_ff] = 1'b1;
               else if (free_ok_ff) valid_in[free_ff] = 1'b1;
            end
            tter_pkg::MODE_DEL:     if (match_ok_ff) valid_in[match_ff] = 1'b0;
            tter_pkg::MODE_DEL_ALL: valid_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff <= '0; valid_ff <= '0; stage_ff <= 1'b0;
      end else begin
         now_ff <= now_in; valid_ff <= valid_in; stage_ff <= cmd.scan_step;
      end
      done_ff <= done_in; idx_ff <= idx_in;
      slot_ff <= cur;
      rd_id_ff <= id_mem[cur]; rd_dl_ff <= dl_mem[cur]; rd_rl_ff <= rl_mem[cur];
      best_ok_ff <= best_ok_in; best_ff <= best_in; blag_ff <= blag_in;
      best_id_ff <= best_id_in; best_dl_ff <= best_dl_in; best_rl_ff <= best_rl_in;
      more_ok_ff <= more_ok_in; fire_cnt_ff <= fire_cnt_in;
      match_ok_ff <= match_ok_in; match_ff <= match_in;
      free_ok_ff <= free_ok_in; free_ff <= free_in;
      if (cmd.take_req) req_ff <= req_payload;
      if (cmd.fire && best_rl_ff != '0)
         dl_mem[best_ff] <= best_dl_ff + TIME_BITS'(best_rl_ff);
      if (cmd.cmd_exec && req_ff.mode == tter_pkg::MODE_ADD && (match_ok_ff || free_ok_ff)) begin
         id_mem[match_ok_ff ? match_ff : free_ff] <= req_ff.timer_id;
         dl_mem[match_ok_ff ? match_ff : free_ff] <= new_dl;
         rl_mem[match_ok_ff ? match_ff : free_ff] <= req_ff.reload_period;
      end
      if (cmd.load_rsp) begin
         if (cmd.fire) begin
            rsp_ff.event_kind     <= tter_pkg::EV_EXPIRED;
            rsp_ff.fired_id       <= best_id_ff;
            rsp_ff.fired_deadline <= 32'(best_dl_ff);
            rsp_ff.last           <= last_fire;
         end else begin
            rsp_ff.last <= 1'b1;
            priority if (req_ff.mode == tter_pkg::MODE_TICK) begin
               rsp_ff.event_kind     <= tter_pkg::EV_EXPIRED;
            end else if (req_ff.mode == tter_pkg::MODE_ADD) begin
               rsp_ff.fired_id       <= req_ff.timer_id;
               if (match_ok_ff || free_ok_ff) begin
                  rsp_ff.event_kind     <= tter_pkg::EV_DONE;
                  rsp_ff.fired_deadline <= 32'(new_dl);
               end else begin
                  rsp_ff.event_kind     <= tter_pkg::EV_FULL;
                  rsp_ff.fired_deadline <= '0;
               end
            end else begin
               rsp_ff.event_kind     <= tter_pkg::EV_DONE;
               rsp_ff.fired_deadline <= '0;
               rsp_ff.fired_id <= (req_ff.mode == tter_pkg::MODE_DEL) ? req_ff.timer_id : 8'd0;
            end
         end
      end
   end

   assign sts.scan_done = (idx_ff == CW'(NUM_TIMERS));
   // includes the compare of the final entry, which lands at the same edge
   assign sts.found     = best_ok_in;
   assign sts.last_fire = last_fire;
   assign sts.is_tick   = (req_ff.mode == tter_pkg::MODE_TICK);
   assign rsp_payload   = rsp_ff;

   a_fire_has_best: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |-> best_ok_ff) else $error("fire without a due entry");
   a_fire_marks_done: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |=> done_ff[$past(best_ff)]) else $error("fired entry not marked");
   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_req && req_payload.mode == tter_pkg::MODE_TICK)
      |=> now_ff == $past(now_ff) + TIME_BITS'(1))
      else $error("time not advanced");
endmodule
`default_nettype wire

### hdl/tter_ctrl.sv
// Sequencer: scan per fired timer, one command per request, output handshake.
`default_nettype none
module tter_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   input  tter_pkg::ctl_sts_type  sts,
   output tter_pkg::ctl_cmd_type  cmd
);
   tter_pkg::state_type state_ff, state_in;
   logic vld_ff, vld_in;
   logic free_out;

   assign free_out = !vld_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tter_pkg::ST_IDLE: if (req_valid) state_in = tter_pkg::ST_FIND;
         tter_pkg::ST_FIND: state_in = tter_pkg::ST_SCAN;
         tter_pkg::ST_SCAN: if (sts.scan_done)
            state_in = !sts.is_tick ? tter_pkg::ST_RESP :
                       (sts.found ? tter_pkg::ST_EMIT : tter_pkg::ST_IDLE);
         tter_pkg::ST_EMIT: if (free_out) state_in = sts.last_fire ? tter_pkg::ST_IDLE
                                                                     : tter_pkg::ST_FIND;
         tter_pkg::ST_RESP: if (free_out) state_in = tter_pkg::ST_IDLE;
         default: state_in = tter_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         tter_pkg::ST_IDLE: begin req_stall = 1'b0; cmd.take_req = req_valid; end
         tter_pkg::ST_FIND: cmd.scan_start = 1'b1;
         tter_pkg::ST_SCAN: cmd.scan_step = !sts.scan_done;
         tter_pkg::ST_EMIT: begin cmd.fire = free_out; cmd.load_rsp = free_out; end
         tter_pkg::ST_RESP: begin cmd.cmd_exec = free_out; cmd.load_rsp = free_out; end
         default: ;
      endcase
   end

   // output beat held until taken; a new one loads only once the register is free
   always_comb begin
      vld_in = vld_ff;
      if (vld_ff && !rsp_stall) vld_in = 1'b0;
      if (cmd.load_rsp) vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tter_pkg::ST_IDLE; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; vld_ff <= vld_in;
      end
   end
   assign rsp_valid = vld_ff;

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> free_out) else $error("result overwritten");
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.take_req |=> state_ff == tter_pkg::ST_FIND) else $error("bad start");
   a_exec_once: assert property (@(posedge clock) disable iff (reset)
      cmd.cmd_exec |=> !cmd.cmd_exec) else $error("command applied twice");
endmodule
`default_nettype wire

### hdl/timer_table_expiry_reload_unit.sv
// Top level of the timer table with expiry and periodic reload.
// Usage:
//  req_ channel carries commands: tick, add/modify, delete, delete all.
//  rsp_ channel returns beats; last marks the final beat of a request.
//  A command gives one beat after one table scan (one entry a cycle
//  through a registered table read); the next request is taken only once
//  that beat has been loaded into the output register.
//  A tick scans the table once per fired timer and returns one beat per due
//  timer in deadline order, at most 16 per tick; a tick where nothing is due
//  returns no beat and frees the input once that one scan ends.
//  Each fired timer costs one full table scan, set by the single-entry
//  compare in the scan loop.
//  Reset clears the time counter and all valid bits; table
//  contents are otherwise not cleared.
//  A stalled result holds its beat; a finished scan waits until the output
//  register frees, so no beat is dropped. One request is in flight at a time.
//  The last flag on a tick is carried on the final expired beat.
`default_nettype none
module timer_table_expiry_reload_unit #(
   parameter int NUM_TIMERS = 16,
   parameter int TIME_BITS  = 32
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  tter_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output tter_pkg::rsp_type  rsp_payload
);
   tter_pkg::ctl_cmd_type cmd;
   tter_pkg::ctl_sts_type sts;
   tter_pkg::rsp_type     dp_rsp;

   tter_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .sts, .cmd
   );

   tter_datapath #(.NUM_TIMERS(NUM_TIMERS), .TIME_BITS(TIME_BITS)) u_dp (
      .clock, .reset, .req_payload, .cmd, .sts, .rsp_payload(dp_rsp)
   );

   // result register lives in the datapath
   always_comb begin
      rsp_payload = dp_rsp;
   end
endmodule
`default_nettype wire

### tb/timer_table_expiry_reload_unit_tb.sv
// Self-checking testbench for the timer table with expiry and periodic reload.
`timescale 1ns / 1ps
module timer_table_expiry_reload_unit_tb;

   localparam int SLOTS      = 16;
   localparam int FIRE_LIMIT = 16;
   localparam longint CYCLE_LIMIT = 2_000_000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   tter_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   tter_pkg::rsp_type rsp_payload;

   timer_table_expiry_reload_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   // predicted table state
   logic [31:0] now_ticks;
   logic        slot_used [SLOTS];
   logic [7:0]  slot_id   [SLOTS];
   logic [31:0] slot_due  [SLOTS];
   logic [15:0] slot_period [SLOTS];

   tter_pkg::rsp_type pending_beats[$];
   int      fail_count = 0;
   bit      idle_enable = 1'b1;
   longint  cycle_count = 0;

   task automatic queue_beat(input tter_pkg::rsp_type beat);
      pending_beats = {pending_beats, beat};
   endtask

   task automatic predict_command(input tter_pkg::req_type cmd);
      int hit;
      int n;
      int pick;
      logic [31:0] lag, pick_lag, dl;
      bit fired [SLOTS];
      tter_pkg::rsp_type beat;
      hit = -1;
      beat = '0;
      unique case (tter_pkg::mode_type'(cmd.mode))
         tter_pkg::MODE_TICK: begin
            foreach (fired[i]) fired[i] = 1'b0;
            now_ticks = now_ticks + 1;
            n = 0;
            while (n < FIRE_LIMIT) begin
               pick = -1;
               pick_lag = 0;
               for (int i = 0; i < SLOTS; i++) begin
                  if (slot_used[i] && !fired[i]) begin
                     lag = now_ticks - slot_due[i];
                     if (!lag[31] && (pick < 0 || lag > pick_lag)) begin
                        pick = i;
                        pick_lag = lag;
                     end
                  end
               end
               if (pick < 0) break;
               fired[pick] = 1'b1;
               beat.event_kind = tter_pkg::EV_EXPIRED;
               beat.fired_id = slot_id[pick];
               beat.fired_deadline = slot_due[pick];
               beat.last = 1'b0;
               queue_beat(beat);
               if (slot_period[pick] != 0)
                  slot_due[pick] = slot_due[pick] + 32'(slot_period[pick]);
               else
                  slot_used[pick] = 1'b0;
               n++;
            end
            if (n > 0) pending_beats[$].last = 1'b1;
         end
         tter_pkg::MODE_ADD: begin
            dl = now_ticks + 32'(cmd.start_delay) + 32'(cmd.expire_delay);
            for (int i = SLOTS - 1; i >= 0; i--)
               if (slot_used[i] && slot_id[i] == cmd.timer_id) hit = i;
            if (hit < 0)
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (!slot_used[i]) hit = i;
            beat.fired_id = cmd.timer_id;
            beat.last = 1'b1;
            if (hit < 0) begin
               beat.event_kind = tter_pkg::EV_FULL;
            end else begin
               slot_used[hit] = 1'b1;
               slot_id[hit] = cmd.timer_id;
               slot_due[hit] = dl;
               slot_period[hit] = cmd.reload_period;
               beat.event_kind = tter_pkg::EV_DONE;
               beat.fired_deadline = dl;
            end
            queue_beat(beat);
         end
         tter_pkg::MODE_DEL: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot_used[i] && slot_id[i] == cmd.timer_id) slot_used[i] = 1'b0;
            beat.event_kind = tter_pkg::EV_DONE;
            beat.fired_id = cmd.timer_id;
            beat.last = 1'b1;
            queue_beat(beat);
         end
         default: begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            beat.event_kind = tter_pkg::EV_DONE;
            beat.last = 1'b1;
            queue_beat(beat);
         end
      endcase
   endtask

   task automatic send_command(input tter_pkg::req_type cmd);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_command(cmd);
      req_valid <= 1'b0;
      // the block is busy scanning here anyway
      @(posedge clock);
   endtask

   function automatic tter_pkg::req_type make_cmd(input tter_pkg::mode_type m,
                                                  input logic [7:0] id,
                                                  input logic [15:0] sd,
                                                  input logic [15:0] ed,
                                                  input logic [15:0] rp);
      tter_pkg::req_type c;
      c.mode = m;
      c.timer_id = id;
      c.start_delay = sd;
      c.expire_delay = ed;
      c.reload_period = rp;
      return c;
   endfunction

   task automatic send_ticks(input int count);
      repeat (count) send_command(make_cmd(tter_pkg::MODE_TICK, 8'($urandom), 16'($urandom),
                                           16'($urandom), 16'($urandom)));
   endtask

   // result checker
   always @(posedge clock) begin
      tter_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected beat %p", rsp_payload);
            fail_count++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_payload.event_kind !== want.event_kind) begin
               $error("event_kind: expected %0d, got %0d", want.event_kind,
                      rsp_payload.event_kind);
               fail_count++;
            end
            if (rsp_payload.fired_id !== want.fired_id) begin
               $error("fired_id: expected %0d, got %0d", want.fired_id,
                      rsp_payload.fired_id);
               fail_count++;
            end
            if (rsp_payload.fired_deadline !== want.fired_deadline) begin
               $error("fired_deadline: expected %0d, got %0d", want.fired_deadline,
                      rsp_payload.fired_deadline);
               fail_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_payload.last);
               fail_count++;
            end
         end
      end
   end

   // receiver stall bursts
   initial begin
      int burst;
      forever begin
         @(posedge clock);
         if (idle_enable && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 18);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic test_commands_extremes();
      send_command(make_cmd(tter_pkg::MODE_ADD, 8'h00, 16'h0000, 16'h0001, 16'h0000));
      send_command(make_cmd(tter_pkg::MODE_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_command(make_cmd(tter_pkg::MODE_ADD, 8'hFF, 16'h0001, 16'h0001, 16'h0003));
      send_command(make_cmd(tter_pkg::MODE_DEL, 8'h55, 16'hFFFF, 16'h0000, 16'hAAAA));
      send_ticks(1);
      send_ticks(1);
      send_ticks(4);
      send_command(make_cmd(tter_pkg::MODE_DEL, 8'hFF, 16'h0000, 16'hFFFF, 16'h5555));
      send_command(make_cmd(tter_pkg::MODE_ADD, 8'h12, 16'h0000, 16'h0000, 16'h0000));
      send_ticks(1);
      send_command(make_cmd(tter_pkg::MODE_DEL_ALL, 8'hAA, 16'h1234, 16'h4321, 16'h0001));
   endtask

   task automatic test_table_full_and_ties();
      for (int i = 0; i < SLOTS; i++)
         send_command(make_cmd(tter_pkg::MODE_ADD, 8'(i * 3), 16'd1, 16'd1, 16'(i % 2)));
      send_command(make_cmd(tter_pkg::MODE_ADD, 8'hC8, 16'd0, 16'd5, 16'd0));
      send_command(make_cmd(tter_pkg::MODE_ADD, 8'd9, 16'd0, 16'd4, 16'd0));
      send_ticks(6);
      send_command(make_cmd(tter_pkg::MODE_DEL_ALL, 8'd0, 16'd0, 16'd0, 16'd0));
   endtask

   // far-future deadline beside a near one: only the near one may fire
   task automatic test_wrap_lag();
      send_command(make_cmd(tter_pkg::MODE_ADD, 8'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_command(make_cmd(tter_pkg::MODE_ADD, 8'd8, 16'd2, 16'd0, 16'd1));
      send_ticks(4);
      send_command(make_cmd(tter_pkg::MODE_DEL_ALL, 8'd0, 16'd0, 16'd0, 16'd0));
   endtask

   task automatic test_random_traffic(input int count);
      tter_pkg::req_type c;
      int pick;
      for (int k = 0; k < count; k++) begin
         if (k > count * 4 / 5) idle_enable = 1'b0;
         pick = $urandom_range(0, 99);
         c = make_cmd(tter_pkg::MODE_TICK, 8'($urandom_range(0, 23)),
                      16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)),
                      16'($urandom_range(0, 5)));
         if (pick < 5) begin
            c.timer_id = 8'($urandom);
            c.start_delay = 16'($urandom);
            c.expire_delay = 16'($urandom);
            c.reload_period = 16'($urandom);
         end
         if (pick < 40) c.mode = tter_pkg::MODE_TICK;
         else if (pick < 80) c.mode = tter_pkg::MODE_ADD;
         else if (pick < 97) c.mode = tter_pkg::MODE_DEL;
         else c.mode = tter_pkg::MODE_DEL_ALL;
         send_command(c);
      end
   endtask

   initial begin
      int waited;
      now_ticks = '0;
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_id[i] = '0;
         slot_due[i] = '0;
         slot_period[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_commands_extremes();
      test_table_full_and_ties();
      test_wrap_lag();
      test_random_traffic(260);
      waited = 0;
      while (pending_beats.size() != 0 && waited < 200_000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_beats.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
